// ----- rtl/swm_pkg.sv -----
// shared types and constants for the sliding window minimum unit
package swm_pkg;

	localparam int DATA_W = 64;

	localparam logic signed [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};

	typedef logic signed [DATA_W-1:0] sample_t;

	typedef struct packed {
		logic    live;
		sample_t minimum;
	} wave_t;

endpackage

// ----- rtl/sliding_window_minimum_unit.sv -----
// top level: sliding window minimum over a shifting chain of sample cells
// path of an item: start_q, the cell chain, pend_q, then the output register
// the minimum wave walks the cell chain one cell per cycle, and the next item waits
// until it has left the chain and its result has moved to the output register
// the output register lets the next item be taken while a result waits
// reset: window empty, fill count zero, no result pending; takes effect at once
module sliding_window_minimum_unit #(
	parameter int WINDOW = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // time_offset[63:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // window_minimum[63:0]
);

	localparam int FW = $clog2(WINDOW + 1);

	logic             accept;
	logic             busy_q;
	logic             start_q;
	logic             pend_q;
	swm_pkg::sample_t pend_data_q;
	logic             out_valid_q;
	swm_pkg::sample_t out_data_q;
	logic [FW-1:0]    fill_q;
	logic             out_free;

	swm_pkg::sample_t samples [WINDOW+1];
	swm_pkg::wave_t   waves   [WINDOW+1];

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign samples[0]       = s_tdata;
	assign waves[0].live    = start_q;
	assign waves[0].minimum = swm_pkg::MAX_POS;

	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		swm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (accept),
			.occupied   (fill_q > FW'(k)),
			.sample_in  (samples[k]),
			.sample_out (samples[k+1]),
			.wave_in    (waves[k]),
			.wave_out   (waves[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fill_q      <= '0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
				if (fill_q < FW'(WINDOW)) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (waves[WINDOW].live) begin
				pend_q <= 1'b1;
			end
			if (pend_q && out_free) begin
				pend_q      <= 1'b0;
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (waves[WINDOW].live) begin
			pend_data_q <= waves[WINDOW].minimum;
		end
		if (pend_q && out_free) begin
			out_data_q <= pend_data_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- rtl/swm_cell.sv -----
// one window cell: holds a sample and folds it into the passing minimum wave
module swm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            occupied,
	input  swm_pkg::sample_t sample_in,
	output swm_pkg::sample_t sample_out,
	input  swm_pkg::wave_t  wave_in,
	output swm_pkg::wave_t  wave_out
);

	swm_pkg::sample_t sample_q;
	logic             live_q;
	swm_pkg::sample_t minimum_q;
	swm_pkg::sample_t folded;

	always_comb begin
		folded = wave_in.minimum;
		if (occupied && (sample_q < wave_in.minimum)) begin
			folded = sample_q;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= sample_in;
		end
		minimum_q <= folded;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else begin
			live_q <= wave_in.live;
		end
	end

	assign sample_out       = sample_q;
	assign wave_out.live    = live_q;
	assign wave_out.minimum = minimum_q;

endmodule

// ----- tb/tb_top.sv -----
// testbench for the sliding window minimum unit: random and directed offset streams
`timescale 1ns / 100ps

module tb_top;

	localparam int WINDOW = 100;
	localparam int LATENCY = WINDOW + 3;
	localparam int HOLD_CYCLES = 600;
	localparam int LIMIT_CYCLES = 4000;
	localparam swm_pkg::sample_t MIN_NEG = {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};

	typedef enum int {PAT_WIDE, PAT_CLUSTER, PAT_RISING, PAT_FALLING} pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // time_offset[63:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // window_minimum[63:0]

	swm_pkg::sample_t offset_history[$];
	swm_pkg::sample_t expected_minimums[$];
	int      error_count = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      idle_cycles = 0;
	logic    hold_token = 1'b0;
	logic    hold_seen = 1'b0;
	int      hold_left = 0;

	sliding_window_minimum_unit #(.WINDOW(WINDOW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic swm_pkg::sample_t next_window_min(input swm_pkg::sample_t offset);
		swm_pkg::sample_t lowest;
		offset_history.push_back(offset);
		if (offset_history.size() > WINDOW)
			void'(offset_history.pop_front());
		lowest = swm_pkg::MAX_POS;
		foreach (offset_history[i])
			if (offset_history[i] < lowest)
				lowest = offset_history[i];
		return lowest;
	endfunction

	task automatic send_offset(input swm_pkg::sample_t offset);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= offset;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_minimums.push_back(next_window_min(offset));
	endtask

	// receiver side: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result check on every output transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_minimums.size() == 0) begin
				$display("%0t: unexpected result, expected none got %0d", $time,
					swm_pkg::sample_t'(m_tdata));
				error_count++;
			end else begin
				swm_pkg::sample_t want;
				want = expected_minimums.pop_front();
				if (swm_pkg::sample_t'(m_tdata) !== want) begin
					$display("%0t: window_minimum mismatch, expected %0d got %0d", $time,
						want, swm_pkg::sample_t'(m_tdata));
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_window_fill;
		send_offset(swm_pkg::MAX_POS);
		send_offset(swm_pkg::MAX_POS);
		send_offset(64'sd1000);
		send_offset(64'sd2000);
		send_offset(64'sd500);
	endtask

	task automatic test_ties;
		send_offset(64'sd500);
		send_offset(64'sd500);
		send_offset(64'sd499);
		send_offset(64'sd499);
	endtask

	task automatic test_extremes;
		send_offset(64'sd0);
		send_offset(64'sd1);
		send_offset(-64'sd1);
		send_offset(swm_pkg::MAX_POS);
		send_offset(swm_pkg::sample_t'(64'h0000_0000_FFFF_FFFF));
		send_offset(swm_pkg::sample_t'(64'hFFFF_FFFF_0000_0000));
		send_offset(MIN_NEG);
		send_offset(MIN_NEG);
		send_offset(swm_pkg::MAX_POS);
	endtask

	function automatic swm_pkg::sample_t random_offset();
		case ($urandom_range(9))
			0: return MIN_NEG;
			1: return swm_pkg::MAX_POS;
			default: return swm_pkg::sample_t'({$urandom, $urandom});
		endcase
	endfunction

	// runs of wide random or related offsets so the minimum drops out of the window often
	task automatic test_random(input int count);
		int               sent;
		int               run_len;
		pattern_t         pattern;
		swm_pkg::sample_t value;
		swm_pkg::sample_t stride;
		sent = 0;
		while (sent < count) begin
			pattern = pattern_t'($urandom_range(3));
			run_len = $urandom_range(1, 150);
			value = random_offset();
			stride = swm_pkg::sample_t'($urandom_range(1, 1000));
			for (int i = 0; i < run_len && sent < count; i++) begin
				case (pattern)
					PAT_WIDE:    send_offset(random_offset());
					PAT_CLUSTER: send_offset(value + swm_pkg::sample_t'($urandom_range(3)));
					PAT_RISING:  send_offset(value + stride * i);
					PAT_FALLING: send_offset(value - stride * i);
				endcase
				sent++;
			end
		end
	endtask

	// output held off while the sender keeps offering, input must stall
	task automatic test_output_stall;
		hold_token <= ~hold_token;
		for (int i = 0; i < 12; i++)
			send_offset(random_offset());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 87;
		test_window_fill();
		test_ties();
		test_extremes();
		test_random(650);

		send_idle_pct = 87;
		recv_idle_pct = 24;
		test_random(650);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_stall();
		test_random(650);

		s_tvalid <= 1'b0;
		while (expected_minimums.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
